/* hdl/psd_pkg.sv */
// shared types, register indexes and helpers for the point-to-segment distance block
// no dependencies
package psd_pkg;

   localparam int RESULT_WIDTH = 64;
   localparam int DEG_THR_WIDTH = 63;
   localparam int AXIS_THR_WIDTH = 31;
   localparam int FIELD_WIDTH = 32;

   // csr register indexes
   localparam logic [0:0] CSR_DEGENERATE = 1'b0;
   localparam logic [0:0] CSR_AXIS = 1'b1;

   // control carried alongside the divider data
   typedef struct packed {
      logic                    valid;
      logic                    interior;
      logic [RESULT_WIDTH-1:0] ep_dist;
   } psd_ctl_type;

   // clamp a wide unsigned value to 64 bits
   function automatic logic [RESULT_WIDTH-1:0] sat64(input logic [127:0] v);
      logic [RESULT_WIDTH-1:0] r;
      r = (|v[127:RESULT_WIDTH]) ? {RESULT_WIDTH{1'b1}} : v[RESULT_WIDTH-1:0];
      return r;
   endfunction

endpackage

/* hdl/psd_if.sv */
// request and response channel interfaces for the point-to-segment distance block
// depends on psd_pkg
interface psd_req_if;
   logic                               valid;
   logic                               ready;
   logic [psd_pkg::FIELD_WIDTH-1:0]    start_x;
   logic [psd_pkg::FIELD_WIDTH-1:0]    start_y;
   logic [psd_pkg::FIELD_WIDTH-1:0]    end_x;
   logic [psd_pkg::FIELD_WIDTH-1:0]    end_y;
   logic [psd_pkg::FIELD_WIDTH-1:0]    query_x;
   logic [psd_pkg::FIELD_WIDTH-1:0]    query_y;

   modport source (output valid, start_x, start_y, end_x, end_y, query_x, query_y,
                   input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, query_x, query_y,
                 output ready);
endinterface

interface psd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [psd_pkg::RESULT_WIDTH-1:0]   squared_distance;
   logic                               endpoint_nearest;

   modport source (output valid, squared_distance, endpoint_nearest, input ready);
   modport sink (input valid, squared_distance, endpoint_nearest, output ready);
endinterface

/* hdl/psd_front.sv */
// front pipeline: differences, products, sums, classification and cross product square
// depends on psd_pkg
module psd_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      start_x,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      start_y,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      end_x,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      end_y,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      query_x,
   input  logic [psd_pkg::FIELD_WIDTH-1:0]      query_y,
   input  logic [psd_pkg::DEG_THR_WIDTH-1:0]    deg_thr,
   input  logic [psd_pkg::AXIS_THR_WIDTH-1:0]   axis_thr,
   output psd_pkg::psd_ctl_type                 ctl_out,
   output logic [4*(2*COORD_WIDTH+2)-1:0]       c2_out,
   output logic [2*COORD_WIDTH+1:0]             dd_out
);
   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int PW  = 2 * DW;
   localparam int SW  = PW + 1;
   localparam int AW  = 2 * W + 2;
   localparam int HW  = AW / 2;
   localparam int C2W = 2 * AW;

   typedef enum logic [1:0] {NEAR_START, NEAR_INTERIOR, NEAR_END} near_type;

   logic signed [W-1:0] sx, sy, ex_c, ey_c, qx, qy;

   // stage 1
   logic v1_ff;
   logic signed [DW-1:0] ex1_ff, ey1_ff, dx1_ff, dy1_ff, ux1_ff, uy1_ff;
   logic signed [DW-1:0] ex1_in, ey1_in, dx1_in, dy1_in, ux1_in, uy1_in;
   // stage 2
   logic v2_ff, az2_ff, az2_in;
   logic signed [PW-1:0] exex_ff, eyey_ff, dxex_ff, dyey_ff, dxey_ff, dyex_ff;
   logic signed [PW-1:0] uxux_ff, uyuy_ff, dxdx_ff, dydy_ff;
   logic [DW-1:0] bx;
   logic use_y;
   // stage 3
   logic v3_ff, az3_ff;
   logic [AW-1:0] dd3_ff, e13_ff, e23_ff;
   logic signed [SW-1:0] n3_ff, cr3_ff;
   logic signed [SW-1:0] dd_s, e1_s, e2_s;
   // stage 4
   psd_pkg::psd_ctl_type ctl4_ff, ctl4_in;
   logic [AW-1:0] cabs4_ff, cabs4_in, dd4_ff;
   logic [SW-1:0] cneg;
   logic degen, nge;
   near_type near;
   // stage 5
   psd_pkg::psd_ctl_type ctl5_ff;
   logic [2*HW-1:0] hh5_ff, hl5_ff, ll5_ff;
   logic [AW-1:0] dd5_ff;
   // stage 6
   psd_pkg::psd_ctl_type ctl6_ff;
   logic [C2W-1:0] c26_ff, c26_in;
   logic [AW-1:0] dd6_ff;

   assign sx   = start_x[W-1:0];
   assign sy   = start_y[W-1:0];
   assign ex_c = end_x[W-1:0];
   assign ey_c = end_y[W-1:0];
   assign qx   = query_x[W-1:0];
   assign qy   = query_y[W-1:0];

   assign ex1_in = DW'(sx) - DW'(ex_c);
   assign ey1_in = DW'(sy) - DW'(ey_c);
   assign dx1_in = DW'(qx) - DW'(ex_c);
   assign dy1_in = DW'(qy) - DW'(ey_c);
   assign ux1_in = DW'(qx) - DW'(sx);
   assign uy1_in = DW'(qy) - DW'(sy);

   // axis choice for the classification
   assign bx     = ex1_ff[DW-1] ? DW'(-ex1_ff) : DW'(ex1_ff);
   assign use_y  = 64'(bx) < 64'(axis_thr);
   assign az2_in = use_y ? (ey1_ff == '0) : (ex1_ff == '0);

   assign dd_s = SW'(exex_ff) + SW'(eyey_ff);
   assign e1_s = SW'(uxux_ff) + SW'(uyuy_ff);
   assign e2_s = SW'(dxdx_ff) + SW'(dydy_ff);

   always_comb begin
      degen = (dd3_ff == '0) || (128'(dd3_ff) < 128'(deg_thr));
      nge   = n3_ff >= $signed({1'b0, dd3_ff});
      if (degen || az3_ff || nge) begin
         near = NEAR_START;
      end else if (!n3_ff[SW-1]) begin
         near = NEAR_INTERIOR;
      end else begin
         near = NEAR_END;
      end
      ctl4_in.valid = v3_ff;
      case (near)
         NEAR_START: begin
            ctl4_in.interior = 1'b0;
            ctl4_in.ep_dist  = psd_pkg::sat64(128'(e13_ff));
         end
         NEAR_INTERIOR: begin
            ctl4_in.interior = 1'b1;
            ctl4_in.ep_dist  = psd_pkg::sat64(128'(e13_ff));
         end
         NEAR_END: begin
            ctl4_in.interior = 1'b0;
            ctl4_in.ep_dist  = psd_pkg::sat64(128'(e23_ff));
         end
         default: begin
            ctl4_in.interior = 1'b0;
            ctl4_in.ep_dist  = psd_pkg::sat64(128'(e13_ff));
         end
      endcase
      cneg     = SW'(-cr3_ff);
      cabs4_in = cr3_ff[SW-1] ? cneg[AW-1:0] : cr3_ff[AW-1:0];
   end

   assign c26_in = (C2W'(hh5_ff) << (2 * HW)) + (C2W'(hl5_ff) << (HW + 1)) + C2W'(ll5_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         ctl5_ff.valid <= 1'b0;
         ctl6_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         ctl4_ff.valid <= ctl4_in.valid;
         ctl5_ff.valid <= ctl4_ff.valid;
         ctl6_ff.valid <= ctl5_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ex1_ff <= ex1_in;
         ey1_ff <= ey1_in;
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         ux1_ff <= ux1_in;
         uy1_ff <= uy1_in;
         exex_ff <= PW'(ex1_ff) * PW'(ex1_ff);
         eyey_ff <= PW'(ey1_ff) * PW'(ey1_ff);
         dxex_ff <= PW'(dx1_ff) * PW'(ex1_ff);
         dyey_ff <= PW'(dy1_ff) * PW'(ey1_ff);
         dxey_ff <= PW'(dx1_ff) * PW'(ey1_ff);
         dyex_ff <= PW'(dy1_ff) * PW'(ex1_ff);
         uxux_ff <= PW'(ux1_ff) * PW'(ux1_ff);
         uyuy_ff <= PW'(uy1_ff) * PW'(uy1_ff);
         dxdx_ff <= PW'(dx1_ff) * PW'(dx1_ff);
         dydy_ff <= PW'(dy1_ff) * PW'(dy1_ff);
         az2_ff  <= az2_in;
         dd3_ff  <= dd_s[AW-1:0];
         e13_ff  <= e1_s[AW-1:0];
         e23_ff  <= e2_s[AW-1:0];
         n3_ff   <= SW'(dxex_ff) + SW'(dyey_ff);
         cr3_ff  <= SW'(dxey_ff) - SW'(dyex_ff);
         az3_ff  <= az2_ff;
         ctl4_ff.interior <= ctl4_in.interior;
         ctl4_ff.ep_dist  <= ctl4_in.ep_dist;
         cabs4_ff <= cabs4_in;
         dd4_ff   <= dd3_ff;
         ctl5_ff.interior <= ctl4_ff.interior;
         ctl5_ff.ep_dist  <= ctl4_ff.ep_dist;
         hh5_ff <= (2*HW)'(cabs4_ff[AW-1:HW]) * (2*HW)'(cabs4_ff[AW-1:HW]);
         hl5_ff <= (2*HW)'(cabs4_ff[AW-1:HW]) * (2*HW)'(cabs4_ff[HW-1:0]);
         ll5_ff <= (2*HW)'(cabs4_ff[HW-1:0]) * (2*HW)'(cabs4_ff[HW-1:0]);
         dd5_ff <= dd4_ff;
         ctl6_ff.interior <= ctl5_ff.interior;
         ctl6_ff.ep_dist  <= ctl5_ff.ep_dist;
         c26_ff <= c26_in;
         dd6_ff <= dd5_ff;
      end
   end

   assign ctl_out = ctl6_ff;
   assign c2_out  = c26_ff;
   assign dd_out  = dd6_ff;

endmodule

/* hdl/psd_div.sv */
// restoring divider pipeline, one quotient bit per stage, for the interior distance
// depends on psd_pkg
module psd_div #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  psd_pkg::psd_ctl_type               ctl_in,
   input  logic [4*(2*COORD_WIDTH+2)-1:0]     c2_in,
   input  logic [2*COORD_WIDTH+1:0]           dd_in,
   output psd_pkg::psd_ctl_type               ctl_out,
   output logic [2*COORD_WIDTH+1:0]           quo_out
);
   localparam int AW  = 2 * COORD_WIDTH + 2;
   localparam int QW  = AW;
   localparam int C2W = 2 * AW;

   psd_pkg::psd_ctl_type ctl_ff [QW];
   logic [AW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [AW-1:0] dd_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      psd_pkg::psd_ctl_type ctl_prev;
      logic [AW-1:0] rem_prev, dd_prev, rem_in;
      logic [QW-1:0] lo_prev, q_prev;
      logic [AW:0]   trial, diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign ctl_prev = ctl_in;
         assign rem_prev = c2_in[C2W-1:QW];
         assign lo_prev  = c2_in[QW-1:0];
         assign q_prev   = '0;
         assign dd_prev  = dd_in;
      end else begin : g_next
         assign ctl_prev = ctl_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign lo_prev  = lo_ff[k-1];
         assign q_prev   = q_ff[k-1];
         assign dd_prev  = dd_ff[k-1];
      end

      assign trial  = {rem_prev, lo_prev[QW-1-k]};
      assign ge     = trial >= {1'b0, dd_prev};
      assign diff   = trial - {1'b0, dd_prev};
      assign rem_in = ge ? diff[AW-1:0] : trial[AW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k].valid <= ctl_prev.valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[k].interior <= ctl_prev.interior;
            ctl_ff[k].ep_dist  <= ctl_prev.ep_dist;
            rem_ff[k] <= rem_in;
            lo_ff[k]  <= lo_prev;
            q_ff[k]   <= {q_prev[QW-2:0], ge};
            dd_ff[k]  <= dd_prev;
         end
      end
   end

   assign ctl_out = ctl_ff[QW-1];
   assign quo_out = q_ff[QW-1];

endmodule

/* hdl/point_segment_distance_2d.sv */
// point_segment_distance_2d: squared distance from a query point to a 2-d segment.
// The block takes one request per clock and returns one response per request, in
// order. It is built from six front stages (differences, products, sums,
// classification, cross-product square), one restoring-divider stage per quotient
// bit (2*COORD_WIDTH+2 stages) and the output register. The whole pipeline moves
// when the output register is empty or being taken, so with rsp ready held high a
// new request enters every cycle. Coordinates are signed fixed point; only the low
// COORD_WIDTH bits of each field are used and sign-extended. Arithmetic is exact
// integer math, so the fraction position does not change the hardware: results
// carry twice the coordinate fraction bits and saturate at all ones. csr writes
// (index 0 degenerate threshold, index 1 axis threshold) are meant only while no
// request is in flight.
// depends on psd_pkg, psd_if, psd_front, psd_div
module point_segment_distance_2d #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   psd_req_if.sink                              req_bus,
   psd_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [0:0]                           csr_index,
   input  logic [psd_pkg::DEG_THR_WIDTH-1:0]    csr_data
);
   localparam int AW  = 2 * COORD_WIDTH + 2;
   localparam int C2W = 2 * AW;

   // global advance: output register free or being drained
   logic en;

   // configuration registers
   logic [psd_pkg::DEG_THR_WIDTH-1:0]  deg_thr_ff;
   logic [psd_pkg::AXIS_THR_WIDTH-1:0] axis_thr_ff;

   // front to divider
   psd_pkg::psd_ctl_type front_ctl, div_ctl;
   logic [C2W-1:0] front_c2;
   logic [AW-1:0]  front_dd, div_quo;

   // output register
   logic                              rsp_valid_ff;
   logic [psd_pkg::RESULT_WIDTH-1:0]  rsp_dist_ff, rsp_dist_in;
   logic                              rsp_ep_ff;

   assign en = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // csr writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         deg_thr_ff  <= psd_pkg::DEG_THR_WIDTH'(1);
         axis_thr_ff <= psd_pkg::AXIS_THR_WIDTH'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            psd_pkg::CSR_DEGENERATE: deg_thr_ff <= csr_data;
            psd_pkg::CSR_AXIS: axis_thr_ff <= csr_data[psd_pkg::AXIS_THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_bus.valid),
      .start_x  (req_bus.start_x),
      .start_y  (req_bus.start_y),
      .end_x    (req_bus.end_x),
      .end_y    (req_bus.end_y),
      .query_x  (req_bus.query_x),
      .query_y  (req_bus.query_y),
      .deg_thr  (deg_thr_ff),
      .axis_thr (axis_thr_ff),
      .ctl_out  (front_ctl),
      .c2_out   (front_c2),
      .dd_out   (front_dd)
   );

   // interior requests take cross^2 / |e|^2, others ride along with their endpoint distance
   psd_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (front_ctl),
      .c2_in   (front_c2),
      .dd_in   (front_dd),
      .ctl_out (div_ctl),
      .quo_out (div_quo)
   );

   // pick interior quotient or endpoint distance
   assign rsp_dist_in = div_ctl.interior ? psd_pkg::sat64(128'(div_quo)) : div_ctl.ep_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_ep_ff   <= !div_ctl.interior;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.squared_distance = rsp_dist_ff;
   assign rsp_bus.endpoint_nearest = rsp_ep_ff;

endmodule

/* hdl/psd_checker.sv */
// port-level checks for point_segment_distance_2d, attached by bind
// depends on psd_pkg
module psd_assertions (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [psd_pkg::RESULT_WIDTH-1:0]  rsp_dist,
   input logic                              rsp_ep
);
   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side moves exactly when the output can move
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output state");

   // stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_dist) && $stable(rsp_ep))
      else $error("response payload changed while stalled");
endmodule

bind point_segment_distance_2d psd_assertions u_psd_assertions (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_dist  (rsp_bus.squared_distance),
   .rsp_ep    (rsp_bus.endpoint_nearest)
);

/* tb/psd_tb_if.sv */
`timescale 1ns / 1ps
// testbench item types: one request and one expected response
// no dependencies
package psd_tb_types;
   typedef struct packed {
      logic [31:0] start_x;
      logic [31:0] start_y;
      logic [31:0] end_x;
      logic [31:0] end_y;
      logic [31:0] query_x;
      logic [31:0] query_y;
   } seg_query_type;

   typedef struct packed {
      logic [63:0] squared_distance;
      logic        endpoint_nearest;
   } seg_answer_type;
endpackage

/* tb/psd_checker.sv */
`timescale 1ns / 1ps
// checker for point_segment_distance_2d: predicts each response from the requests
// depends on psd_pkg, psd_if, psd_tb_types
module psd_checker (
   input  logic                             clock,
   input  logic                             reset,
   psd_req_if                               req_bus,
   psd_rsp_if                               rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [0:0]                       csr_index,
   input  logic [psd_pkg::DEG_THR_WIDTH-1:0] csr_data,
   output int                               fail_count,
   output int                               pending_count
);
   logic [62:0] deg_thr;
   logic [30:0] axis_thr;
   psd_tb_types::seg_answer_type answers_due[$];

   function automatic logic [63:0] clamp64(input logic signed [159:0] v);
      return (|v[159:64]) ? {64{1'b1}} : v[63:0];
   endfunction

   function automatic logic [63:0] sq_dist(input logic signed [159:0] dx,
                                           input logic signed [159:0] dy);
      return clamp64(dx * dx + dy * dy);
   endfunction

   function automatic psd_tb_types::seg_answer_type nearest_distance(
      input psd_tb_types::seg_query_type q);
      logic signed [159:0] x1, y1, x2, y2, qx, qy, ex, ey, dx, dy, dd, n, cr;
      logic [159:0] c2, quo;
      logic [159:0] bx;
      logic use_y, axis_zero;
      psd_tb_types::seg_answer_type a;
      x1 = $signed(q.start_x); y1 = $signed(q.start_y);
      x2 = $signed(q.end_x);   y2 = $signed(q.end_y);
      qx = $signed(q.query_x); qy = $signed(q.query_y);
      ex = x1 - x2; ey = y1 - y2;
      dx = qx - x2; dy = qy - y2;
      dd = ex * ex + ey * ey;
      if (dd == 0 || dd < {97'd0, deg_thr}) begin
         a.squared_distance = sq_dist(qx - x1, qy - y1);
         a.endpoint_nearest = 1'b1;
         return a;
      end
      n = dx * ex + dy * ey;
      bx = (ex < 0) ? -ex : ex;
      use_y = bx < {129'd0, axis_thr};
      axis_zero = use_y ? (ey == 0) : (ex == 0);
      if (axis_zero || n >= dd) begin
         a.squared_distance = sq_dist(qx - x1, qy - y1);
         a.endpoint_nearest = 1'b1;
      end else if (n >= 0) begin
         cr = dx * ey - dy * ex;
         c2 = cr * cr;
         quo = c2 / dd;
         a.squared_distance = (|quo[159:64]) ? {64{1'b1}} : quo[63:0];
         a.endpoint_nearest = 1'b0;
      end else begin
         a.squared_distance = sq_dist(qx - x2, qy - y2);
         a.endpoint_nearest = 1'b1;
      end
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending_count = answers_due.size();

   always @(posedge clock) begin
      psd_tb_types::seg_query_type q;
      psd_tb_types::seg_answer_type want;
      if (reset) begin
         deg_thr <= 63'd1;
         axis_thr <= 31'd1;
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == psd_pkg::CSR_DEGENERATE) deg_thr <= csr_data;
            else if (csr_index == psd_pkg::CSR_AXIS) axis_thr <= csr_data[30:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            q = {req_bus.start_x, req_bus.start_y, req_bus.end_x, req_bus.end_y,
                 req_bus.query_x, req_bus.query_y};
            answers_due.push_back(nearest_distance(q));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected response", rsp_bus.squared_distance, 64'd0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.squared_distance !== want.squared_distance)
                  report_mismatch("squared_distance", rsp_bus.squared_distance,
                                  want.squared_distance);
               if (rsp_bus.endpoint_nearest !== want.endpoint_nearest)
                  report_mismatch("endpoint_nearest", 64'(rsp_bus.endpoint_nearest),
                                  64'(want.endpoint_nearest));
            end
         end
      end
   end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// top of the point_segment_distance_2d testbench: clock, reset, stimulus, verdict
// depends on psd_pkg, psd_if, psd_tb_types, psd_checker and the block
module tb;
   localparam int LATENCY = 73;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [0:0] csr_index = psd_pkg::CSR_DEGENERATE;
   logic [psd_pkg::DEG_THR_WIDTH-1:0] csr_data = '0;
   int fail_count, pending_count;
   int burst_left = 0, gap_left = 0;
   bit sender_hold = 1'b0;

   psd_req_if req_bus ();
   psd_rsp_if rsp_bus ();

   psd_tb_types::seg_query_type stim_q[$];

   always #4 clock = ~clock;

   point_segment_distance_2d uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   psd_checker check (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // sender: drains stim_q in bursts with random gaps
   always @(posedge clock) begin
      psd_tb_types::seg_query_type q;
      if (reset) begin
         req_bus.valid <= 1'b0;
         {req_bus.start_x, req_bus.start_y, req_bus.end_x, req_bus.end_y,
          req_bus.query_x, req_bus.query_y} <= '0;
      end else begin
         // a request goes away once accepted
         if (req_bus.valid && req_bus.ready) void'(stim_q.pop_front());
         if (gap_left > 0) gap_left--;
         else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         // present the next request when one is queued, the sender is not held and we are in a burst
         if (!sender_hold && gap_left == 0 && stim_q.size() > 0) begin
            q = stim_q[0];
            req_bus.valid <= 1'b1;
            {req_bus.start_x, req_bus.start_y, req_bus.end_x, req_bus.end_y,
             req_bus.query_x, req_bus.query_y} <= q;
            if (burst_left > 0) burst_left--;
         end else if (!(req_bus.valid && !req_bus.ready)) begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern, with long open stretches
   int rx_phase = 0;
   always @(posedge clock) begin
      rx_phase++;
      if (reset) rsp_bus.ready <= 1'b0;
      else if ((rx_phase / 300) % 3 == 0) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(0, 3) != 0);
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom_range(0, 64) - 32;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed segments near the query, some wide and degenerate ones
   function automatic psd_tb_types::seg_query_type rand_query();
      psd_tb_types::seg_query_type q;
      int span;
      span = 1 << $urandom_range(2, 30);
      q.start_x = $urandom; q.start_y = $urandom;
      if ($urandom_range(0, 4) == 0) begin
         q = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord()};
      end else begin
         q.start_x = $urandom_range(0, 2 * span) - span;
         q.start_y = $urandom_range(0, 2 * span) - span;
         q.end_x = (($urandom_range(0, 5) == 0) ? q.start_x :
                    $urandom_range(0, 2 * span) - span);
         q.end_y = $urandom_range(0, 2 * span) - span;
         if ($urandom_range(0, 9) == 0) q.end_y = q.start_y;
         q.query_x = $urandom_range(0, 4 * span) - 2 * span;
         q.query_y = $urandom_range(0, 4 * span) - 2 * span;
      end
      return q;
   endfunction

   // one write cycle, then write enable drops again so back-to-back writes stay apart
   task automatic csr_write(input logic [0:0] idx, input logic [62:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every request to be sent and answered, then let the pipe settle
   task automatic drain();
      while (stim_q.size() > 0 || req_bus.valid || pending_count > 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) stim_q.push_back(rand_query());
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate, endpoint sides, interior, vertical segment
      stim_q.push_back({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
      stim_q.push_back({32'h10, 32'h10, 32'h10, 32'h10, 32'h20, 32'h30});
      stim_q.push_back({32'h0, 32'h0, 32'h100, 32'h0, 32'h80, 32'h40});
      stim_q.push_back({32'h0, 32'h0, 32'h100, 32'h0, 32'h200, 32'h40});
      stim_q.push_back({32'h0, 32'h0, 32'h100, 32'h0, -32'sh80, 32'h40});
      stim_q.push_back({32'h0, 32'h0, 32'h0, 32'h100, 32'h40, 32'h80});
      stim_q.push_back({32'h0, 32'h0, 32'h0, 32'h100, 32'h40, -32'sh80});
      stim_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff});
      stim_q.push_back({32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h0, 32'h0});
      stim_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff});
      stim_q.push_back({32'hffff_ffff, 32'hffff_ffff, 32'h1, 32'h1, 32'h5555_5555,
                        32'haaaa_aaaa});
      stim_q.push_back({32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h7fff_ffff});
      drain();

      // big thresholds: most segments degenerate, y axis decides
      csr_write(psd_pkg::CSR_DEGENERATE, 63'h7fff_ffff_ffff_ffff);
      csr_write(psd_pkg::CSR_AXIS, 63'h7fff_ffff);
      stim_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h0, 32'h0});
      stim_q.push_back({32'h0, 32'h0, 32'h100, 32'h0, 32'h80, 32'h40});
      run_random(150);

      // zero thresholds
      csr_write(psd_pkg::CSR_DEGENERATE, 63'd0);
      csr_write(psd_pkg::CSR_AXIS, 63'd0);
      stim_q.push_back({32'h5, 32'h5, 32'h5, 32'h5, 32'h9, 32'h9});
      run_random(250);

      // pause the sender until everything is answered, mid-run
      sender_hold = 1'b1;
      drain();
      sender_hold = 1'b0;

      // mid-range thresholds
      csr_write(psd_pkg::CSR_DEGENERATE,
                63'({$urandom, $urandom} >> ($urandom_range(1, 60))));
      csr_write(psd_pkg::CSR_AXIS,
                63'($urandom_range(0, 32'h7fff_ffff) >> $urandom_range(0, 30)));
      run_random(300);

      // back to reset values
      csr_write(psd_pkg::CSR_DEGENERATE, 63'd1);
      csr_write(psd_pkg::CSR_AXIS, 63'd1);
      run_random(400);

      if (fail_count == 0) $display("[point_segment_distance_2d] OK");
      else $display("[point_segment_distance_2d] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("[point_segment_distance_2d] ERROR");
      $finish;
   end
endmodule
